### src/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg: shared types and constants of the generational handle table
// Operation and status codes, the packed id layout, the slot row layout and
// the command beat that travels from the front end to the engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

	// Field widths fixed by the interface
	localparam int TYPE_W        = 8;
	localparam int GEN_W         = 16;
	localparam int HANDLE_PORT_W = 32;
	localparam int ID_W          = 64;
	localparam int ID_SLOT_W     = 24;
	localparam int ID_TYPE_LSB   = 56;
	localparam int ID_GEN_LSB    = 32;
	localparam int OP_W          = 2;
	localparam int STATUS_W      = 2;

	// Capacity register
	localparam int             CFG_W     = 9;
	localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;
	localparam int             CFG_MAX   = (1 << CFG_W) - 1;

	// A slot at this generation is retired for good
	localparam logic [GEN_W-1:0] GEN_RETIRED = 16'hFFFF;

	// Operation codes
	localparam logic [OP_W-1:0] OP_ASSIGN = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_W-1:0] OP_DETACH = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

	// Command queue depth
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = 1;
	localparam int CMDQ_CNT_W = 2;

	// Work kinds decided by the front end
	typedef enum logic [1:0] {
		K_ASSIGN = 2'd0,
		K_LOOKUP = 2'd1,
		K_DETACH = 2'd2,
		K_REJECT = 2'd3
	} cmd_kind_t;

	// Command beat: rtype is the type to store on assign, else the id's type
	typedef struct packed {
		cmd_kind_t                  kind;
		logic [TYPE_W-1:0]          rtype;
		logic [HANDLE_PORT_W-1:0]   handle;
		logic [ID_SLOT_W-1:0]       slot;
		logic [GEN_W-1:0]           gen;
	} cmd_t;

	// One slot row of the metadata memory
	typedef struct packed {
		logic              occ;
		logic [TYPE_W-1:0] rtype;
		logic [GEN_W-1:0]  gen;
	} meta_t;

endpackage

`default_nettype wire

### src/ght_front.sv
// ----------------------------------------------------------------------------
// ght_front: input stage of the handle table
// Accepts request beats, runs the checks that need no table access (slot
// bound, expected type, unknown operation) and hands commands to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_front #(
	parameter int DEPTH = 256
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [$clog2(DEPTH+1)-1:0]          cap,
	input  wire logic                                init_done,
	input  wire logic                                in_valid,
	output      logic                                in_ready,
	input  wire logic [ght_pkg::OP_W-1:0]            operation,
	input  wire logic [ght_pkg::TYPE_W-1:0]          type_code,
	input  wire logic [ght_pkg::HANDLE_PORT_W-1:0]   resource_handle,
	input  wire logic [ght_pkg::ID_W-1:0]            packed_id,
	output      logic                                push,
	output      ght_pkg::cmd_t                       push_cmd,
	input  wire logic                                q_full
);
	import ght_pkg::*;

	logic                  v_s1;
	cmd_t                  cmd_s1;
	cmd_t                  cls;
	logic                  in_range;
	logic                  type_ok;
	logic [TYPE_W-1:0]     id_type;
	logic                  take;

	assign id_type  = packed_id[ID_TYPE_LSB +: TYPE_W];
	assign in_range = packed_id[ID_SLOT_W-1:0] < ID_SLOT_W'(cap);
	assign type_ok  = id_type == type_code;

	// Classify the request
	always_comb begin
		cls.kind   = K_REJECT;
		cls.rtype  = id_type;
		cls.handle = resource_handle;
		cls.slot   = packed_id[ID_SLOT_W-1:0];
		cls.gen    = packed_id[ID_GEN_LSB +: GEN_W];
		case (operation)
			OP_ASSIGN: begin
				cls.kind  = K_ASSIGN;
				cls.rtype = type_code;
			end
			OP_LOOKUP: begin
				if (in_range && type_ok) begin
					cls.kind = K_LOOKUP;
				end
			end
			OP_DETACH: begin
				if (in_range) begin
					cls.kind = K_DETACH;
				end
			end
			default: begin
				cls.kind = K_REJECT;
			end
		endcase
	end

	// Hold off inputs during the clearing pass and while the stage is stuck
	assign in_ready = init_done && (!v_s1 || !q_full);
	assign take     = in_valid && in_ready;
	assign push     = v_s1 && !q_full;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cls;
		end
	end

endmodule

`default_nettype wire

### src/ght_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ght_cmd_fifo: command queue between front end and engine
// A short first-in first-out queue of classified command beats.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_cmd_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire ght_pkg::cmd_t  push_cmd,
	output      logic           full,
	input  wire logic           pop,
	output      logic           head_valid,
	output      ght_pkg::cmd_t  head_cmd
);
	import ght_pkg::*;

	cmd_t                    entry_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0]   wr_ptr_q;
	logic [CMDQ_PTR_W-1:0]   rd_ptr_q;
	logic [CMDQ_CNT_W-1:0]   count_q;
	logic                    do_push;
	logic                    do_pop;

	assign full       = count_q == CMDQ_CNT_W'(CMDQ_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
					: CMDQ_PTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
					: CMDQ_PTR_W'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= CMDQ_CNT_W'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= CMDQ_CNT_W'(count_q - 1'b1);
			end
		end
	end

	// Store the beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

### src/ght_engine.sv
// ----------------------------------------------------------------------------
// ght_engine: table engine of the handle table
// Owns the slot memories, runs the clearing pass after reset, the round-robin
// free-slot scan for assign and the read-check-write of lookup and detach,
// and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_engine #(
	parameter int DEPTH    = 256,
	parameter int HANDLE_W = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [$clog2(DEPTH+1)-1:0]          cap,
	output      logic                                init_done,
	input  wire logic                                q_valid,
	input  wire ght_pkg::cmd_t                       q_cmd,
	output      logic                                q_pop,
	output      logic                                out_valid,
	input  wire logic                                out_ready,
	output      logic [ght_pkg::STATUS_W-1:0]        status,
	output      logic [ght_pkg::ID_W-1:0]            assigned_id,
	output      logic [ght_pkg::HANDLE_PORT_W-1:0]   found_handle
);
	import ght_pkg::*;

	localparam int CAP_W = $clog2(DEPTH + 1);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_WRAP  = 5'b00100,
		S_SCAN  = 5'b01000,
		S_CHECK = 5'b10000
	} eng_state_t;

	// Slot memories
	meta_t                meta_mem [DEPTH];
	logic [HANDLE_W-1:0]  hdl_mem  [DEPTH];
	meta_t                meta_rd_q;
	logic [HANDLE_W-1:0]  hdl_rd_q;

	// Control and scan registers
	eng_state_t           state_q, state_d;
	cmd_t                 cmd_q;
	logic [AW-1:0]        ptr_q, ptr_d;
	logic [CAP_W-1:0]     cnt_q, cnt_d;
	logic                 rv_s1, rv_d;
	logic                 last_s1, last_d;
	logic [AW-1:0]        slot_s1, slot_d;
	logic [AW-1:0]        scan_q, scan_d;
	logic [AW-1:0]        clr_q, clr_d;
	logic                 cmd_load;

	// Memory ports
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic                 meta_we;
	logic [AW-1:0]        meta_wa;
	meta_t                meta_wd;
	logic                 hdl_we;

	// Result load
	logic                 out_valid_q;
	logic                 out_free;
	logic                 res_load;
	logic [STATUS_W-1:0]  res_status;
	logic [ID_W-1:0]      res_id;
	logic [HANDLE_PORT_W-1:0] res_handle;

	// Helpers
	logic [CAP_W-1:0]     ptr_ext;
	logic [CAP_W-1:0]     slot_ext;
	logic                 free_hit;
	logic                 id_match;
	logic [GEN_W-1:0]     gen_inc;
	logic [HANDLE_PORT_W-1:0] hdl_ext;

	assign out_free  = !out_valid_q || out_ready;
	assign init_done = state_q != S_CLEAR;
	assign ptr_ext   = CAP_W'(ptr_q);
	assign slot_ext  = CAP_W'(slot_s1);
	assign free_hit  = !meta_rd_q.occ && (meta_rd_q.gen != GEN_RETIRED);
	assign id_match  = meta_rd_q.occ && (meta_rd_q.rtype == cmd_q.rtype)
		&& (meta_rd_q.gen == cmd_q.gen);
	assign gen_inc   = GEN_W'(meta_rd_q.gen + 1'b1);

	always_comb begin
		hdl_ext = '0;
		hdl_ext[HANDLE_W-1:0] = hdl_rd_q;
	end

	// Sequence the table work
	always_comb begin
		state_d    = state_q;
		ptr_d      = ptr_q;
		cnt_d      = cnt_q;
		rv_d       = 1'b0;
		last_d     = last_s1;
		slot_d     = slot_s1;
		scan_d     = scan_q;
		clr_d      = clr_q;
		cmd_load   = 1'b0;
		q_pop      = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = ptr_q;
		meta_we    = 1'b0;
		meta_wa    = slot_s1;
		meta_wd    = '0;
		hdl_we     = 1'b0;
		res_load   = 1'b0;
		res_status = ST_NOT_FOUND;
		res_id     = '0;
		res_handle = '0;
		case (state_q)
			S_CLEAR: begin
				meta_we = 1'b1;
				meta_wa = clr_q;
				clr_d   = AW'(clr_q + 1'b1);
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (q_valid && out_free) begin
					q_pop    = 1'b1;
					cmd_load = 1'b1;
					case (q_cmd.kind)
						K_ASSIGN: begin
							if (cap == '0) begin
								res_load   = 1'b1;
								res_status = ST_FULL;
							end else begin
								ptr_d   = scan_q;
								cnt_d   = '0;
								state_d = S_WRAP;
							end
						end
						K_LOOKUP, K_DETACH: begin
							rd_en   = 1'b1;
							rd_addr = q_cmd.slot[AW-1:0];
							state_d = S_CHECK;
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			S_WRAP: begin
				// Bring the scan start below the capacity
				if (ptr_ext >= cap) begin
					ptr_d = AW'(ptr_ext - cap);
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				// Issue the next slot read
				if (cnt_q != cap) begin
					rd_en   = 1'b1;
					rd_addr = ptr_q;
					ptr_d   = (CAP_W'(ptr_ext + 1'b1) == cap) ? '0 : AW'(ptr_q + 1'b1);
					cnt_d   = CAP_W'(cnt_q + 1'b1);
					rv_d    = 1'b1;
					last_d  = CAP_W'(cnt_q + 1'b1) == cap;
					slot_d  = ptr_q;
				end
				// Check the slot read in the previous cycle
				if (rv_s1) begin
					if (free_hit) begin
						meta_we    = 1'b1;
						meta_wa    = slot_s1;
						meta_wd.occ   = 1'b1;
						meta_wd.rtype = cmd_q.rtype;
						meta_wd.gen   = gen_inc;
						hdl_we     = 1'b1;
						res_load   = 1'b1;
						res_status = ST_OK;
						res_id[ID_TYPE_LSB +: TYPE_W] = cmd_q.rtype;
						res_id[ID_GEN_LSB +: GEN_W]   = gen_inc;
						res_id[AW-1:0]                = slot_s1;
						scan_d  = (CAP_W'(slot_ext + 1'b1) == cap) ? '0
							: AW'(slot_s1 + 1'b1);
						rv_d    = 1'b0;
						state_d = S_IDLE;
					end else if (last_s1) begin
						res_load   = 1'b1;
						res_status = ST_FULL;
						rv_d       = 1'b0;
						state_d    = S_IDLE;
					end
				end
			end
			S_CHECK: begin
				res_load = 1'b1;
				if (id_match) begin
					res_status = ST_OK;
					res_handle = hdl_ext;
					if (cmd_q.kind == K_DETACH) begin
						meta_we       = 1'b1;
						meta_wa       = cmd_q.slot[AW-1:0];
						meta_wd.occ   = 1'b0;
						meta_wd.rtype = '0;
						meta_wd.gen   = meta_rd_q.gen;
					end
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			scan_q      <= '0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			scan_q  <= scan_d;
			rv_s1   <= rv_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		ptr_q   <= ptr_d;
		cnt_q   <= cnt_d;
		last_s1 <= last_d;
		slot_s1 <= slot_d;
		if (cmd_load) begin
			cmd_q <= q_cmd;
		end
		if (res_load) begin
			status       <= res_status;
			assigned_id  <= res_id;
			found_handle <= res_handle;
		end
	end

	// Slot metadata memory
	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_wa] <= meta_wd;
		end
		if (rd_en) begin
			meta_rd_q <= meta_mem[rd_addr];
		end
	end

	// Stored handle memory
	always_ff @(posedge clk) begin
		if (hdl_we) begin
			hdl_mem[slot_s1] <= cmd_q.handle[HANDLE_W-1:0];
		end
		if (rd_en) begin
			hdl_rd_q <= hdl_mem[rd_addr];
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### src/generational_handle_table.sv
// Generational handle table. Each slot keeps an occupied flag, a handle, an
// 8-bit type and a 16-bit generation; assign hands out ids packed as
// type<<56 | generation<<32 | slot, and lookup and detach check an id against
// its slot. After reset a clearing pass writes one slot row per cycle,
// min(SLOT_COUNT, 511) rows in all, during which in_ready stays low. A
// request is registered in the input stage, held there while the queue is
// full, and then waits in a two-entry command queue for the engine, which
// starts a command once the result register is free. In the engine, a
// rejected request loads its result from the idle state, and lookup or
// detach reads the slot, then checks it and writes back. Assign settles the
// round-robin start below the capacity by repeated subtraction (none unless
// the capacity was lowered), then reads one slot per cycle, each checked in
// the cycle after its read, until a free slot is found.
// ----------------------------------------------------------------------------
// generational_handle_table: top level
// Capacity register, input stage, command queue and table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_table #(
	parameter int SLOT_COUNT  = 256,
	parameter int HANDLE_BITS = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output      logic                                cfg_ready,
	input  wire logic [ght_pkg::CFG_W-1:0]           cfg_data,
	input  wire logic                                in_valid,
	output      logic                                in_ready,
	input  wire logic [ght_pkg::OP_W-1:0]            operation,
	input  wire logic [ght_pkg::TYPE_W-1:0]          type_code,
	input  wire logic [ght_pkg::HANDLE_PORT_W-1:0]   resource_handle,
	input  wire logic [ght_pkg::ID_W-1:0]            packed_id,
	output      logic                                out_valid,
	input  wire logic                                out_ready,
	output      logic [ght_pkg::STATUS_W-1:0]        status,
	output      logic [ght_pkg::ID_W-1:0]            assigned_id,
	output      logic [ght_pkg::HANDLE_PORT_W-1:0]   found_handle
);
	import ght_pkg::*;

	// Only slots below the largest programmable capacity are ever reached
	localparam int DEPTH    = (SLOT_COUNT < CFG_MAX) ? SLOT_COUNT : CFG_MAX;
	localparam int CAP_W    = $clog2(DEPTH + 1);
	localparam int HANDLE_W = (HANDLE_BITS < HANDLE_PORT_W) ? HANDLE_BITS : HANDLE_PORT_W;

	logic [CFG_W-1:0]  slots_in_use_q;
	logic [CAP_W-1:0]  cap;
	logic              init_done;
	logic              push;
	cmd_t              push_cmd;
	logic              q_full;
	logic              q_pop;
	logic              q_valid;
	cmd_t              q_cmd;

	// Capacity register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			slots_in_use_q <= cfg_data;
		end
	end

	// Saturate the capacity to the built slot count
	assign cap = (slots_in_use_q > CFG_W'(DEPTH)) ? CAP_W'(DEPTH)
		: CAP_W'(slots_in_use_q);

	ght_front #(
		.DEPTH (DEPTH)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cap             (cap),
		.init_done       (init_done),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.type_code       (type_code),
		.resource_handle (resource_handle),
		.packed_id       (packed_id),
		.push            (push),
		.push_cmd        (push_cmd),
		.q_full          (q_full)
	);

	ght_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_cmd   (q_cmd)
	);

	ght_engine #(
		.DEPTH    (DEPTH),
		.HANDLE_W (HANDLE_W)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cap          (cap),
		.init_done    (init_done),
		.q_valid      (q_valid),
		.q_cmd        (q_cmd),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.assigned_id  (assigned_id),
		.found_handle (found_handle)
	);

endmodule

`default_nettype wire
